### sv/jtwv_pkg.sv
// ----------------------------------------------------------------------------
// Joystick to wheel velocities: shared package
// Field widths, the motion code, and the sideband word that rides alongside
// the divider pipeline.
// ----------------------------------------------------------------------------
package jtwv_pkg;

   // port field widths
   localparam int RADIUS_W = 11;
   localparam int ANGLE_W  = 10;
   localparam int TRACK_W  = 10;
   localparam int SPEED_W  = 19;
   localparam int CASE_W   = 3;

   // internal widths
   localparam int VEL_W  = 15;   // 10 * radius, radius below 2048
   localparam int TURN_W = 8;    // triangle value, 4 .. 156
   localparam int PROD_W = 22;   // vel * 157
   localparam int NUM_W  = 32;   // vel * 157 * track width
   localparam int DSR_W  = 12;   // 17 * triangle value
   localparam int ADD_W  = 33;   // numerator plus rounding half

   localparam logic [TRACK_W-1:0] TRACK_RESET = 10'd128;

   localparam int SPEED_MAX = 262143;
   localparam int SPEED_MIN = -262144;

   typedef enum logic [CASE_W-1:0] {
      MC_HARD_RIGHT,
      MC_RIGHT,
      MC_STRAIGHT,
      MC_LEFT,
      MC_HARD_LEFT,
      MC_BACK_LEFT,
      MC_BACK,
      MC_BACK_RIGHT
   } motion_type;

   // values carried past the divider
   typedef struct packed {
      logic [VEL_W-1:0] vel;
      motion_type       mcase;
      logic             straight;
      logic             outer_left;  // left wheel takes v + d
      logic             back;
   } side_type;

   localparam int SIDE_W = $bits(side_type);

endpackage

### sv/jtwv_if.sv
// ----------------------------------------------------------------------------
// Joystick to wheel velocities: channel interfaces
// Valid/ready channels for the joystick word and the wheel speed word.
// ----------------------------------------------------------------------------
interface jtwv_req_if import jtwv_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RADIUS_W-1:0] stick_radius;
   logic [ANGLE_W-1:0]  stick_angle;

   modport source (output valid, output stick_radius, output stick_angle, input ready);
   modport sink   (input valid, input stick_radius, input stick_angle, output ready);
endinterface

interface jtwv_rsp_if import jtwv_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] right_speed;
   logic signed [SPEED_W-1:0] left_speed;
   logic [CASE_W-1:0]         motion_case;

   modport source (output valid, output right_speed, output left_speed,
                   output motion_case, input ready);
   modport sink   (input valid, input right_speed, input left_speed,
                   input motion_case, output ready);
endinterface

### sv/joystick_to_wheel_velocities_unit.sv
// ----------------------------------------------------------------------------
// Joystick to wheel velocities
// Turns a polar joystick word into left and right wheel speeds.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one joystick word (radius, angle in centiradians) with
//   valid/ready; rsp_ch returns one word per request: right and left wheel
//   speeds, saturated to 19 signed bits, and the motion case code.
//   csr_wr_en / csr_wr_data load the track width; write it only while no
//   word is in flight.
// Pipeline: depth depends on FRACTION_BITS, from accept to rsp_ch.valid:
//   four front stages, one divider stage per quotient bit
//   (33 - FRACTION_BITS), one output register; each stage holds one word.
// Throughput: one word per cycle while rsp_ch.ready is high.
// Reset: empties the pipeline and sets the track width to 128 (0.5 m).
// Stall: when rsp_ch.ready is low the output word holds; stages behind it
//   keep filling empty slots, and req_ch.ready drops only once every stage
//   holds a word.
// ----------------------------------------------------------------------------
module joystick_to_wheel_velocities_unit import jtwv_pkg::*; #(
   parameter int FRACTION_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   jtwv_req_if.sink           req_ch,
   jtwv_rsp_if.source         rsp_ch,
   input  logic               csr_wr_en,
   input  logic [TRACK_W-1:0] csr_wr_data
);

   localparam int DVD_W = ADD_W - FRACTION_BITS;

   logic [TRACK_W-1:0] track_width_ff;

   logic             f_valid, f_ready;
   logic [DVD_W-1:0] f_dvd;
   logic [DSR_W-1:0] f_dsr;
   side_type         f_side;

   logic              d_valid, d_ready;
   logic [DVD_W-1:0]  d_quo;
   logic [SIDE_W-1:0] d_tag;

   // track width register
   always_ff @(posedge clock) begin
      if (reset) begin
         track_width_ff <= TRACK_RESET;
      end else if (csr_wr_en) begin
         track_width_ff <= csr_wr_data;
      end
   end

   jtwv_front #(
      .FRACTION_BITS (FRACTION_BITS),
      .DVD_W         (DVD_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .track_width (track_width_ff),
      .out_valid   (f_valid),
      .out_ready   (f_ready),
      .out_dvd     (f_dvd),
      .out_dsr     (f_dsr),
      .out_side    (f_side)
   );

   jtwv_div #(
      .DVD_W (DVD_W),
      .TAG_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_dvd    (f_dvd),
      .in_dsr    (f_dsr),
      .in_tag    (f_side),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_quo   (d_quo),
      .out_tag   (d_tag)
   );

   jtwv_back #(
      .DVD_W (DVD_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (d_valid),
      .in_ready (d_ready),
      .in_quo   (d_quo),
      .in_side  (side_type'(d_tag)),
      .rsp_ch   (rsp_ch)
   );

`ifndef SYNTHESIS
   // straight ahead drives both wheels forward alike
   a_straight: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.motion_case == MC_STRAIGHT) |->
      (rsp_ch.right_speed == rsp_ch.left_speed && rsp_ch.right_speed >= 0))
      else $error("straight ahead word with unequal or negative speeds");

   // straight back drives both wheels backward alike
   a_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.motion_case == MC_BACK) |->
      (rsp_ch.right_speed == rsp_ch.left_speed && rsp_ch.right_speed <= 0))
      else $error("straight back word with unequal or positive speeds");

   // turning right: left wheel never slower than right
   a_turn_right: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.motion_case == MC_HARD_RIGHT ||
                        rsp_ch.motion_case == MC_RIGHT ||
                        rsp_ch.motion_case == MC_BACK_LEFT)) |->
      (rsp_ch.left_speed >= rsp_ch.right_speed))
      else $error("right turn with left wheel below right wheel");

   // turning left: right wheel never slower than left
   a_turn_left: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.motion_case == MC_LEFT ||
                        rsp_ch.motion_case == MC_HARD_LEFT ||
                        rsp_ch.motion_case == MC_BACK_RIGHT)) |->
      (rsp_ch.right_speed >= rsp_ch.left_speed))
      else $error("left turn with right wheel below left wheel");
`endif

endmodule

### sv/jtwv_front.sv
// ----------------------------------------------------------------------------
// Joystick to wheel velocities: front pipeline
// Four stages: angle decode and speed, speed times 157, times track width,
// then add the rounding half and drop the fraction bits to form the dividend.
// ----------------------------------------------------------------------------
module jtwv_front import jtwv_pkg::*; #(
   parameter int FRACTION_BITS = 8,
   parameter int DVD_W         = 25
) (
   input  logic               clock,
   input  logic               reset,
   jtwv_req_if.sink           req_ch,
   input  logic [TRACK_W-1:0] track_width,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [DVD_W-1:0]   out_dvd,
   output logic [DSR_W-1:0]   out_dsr,
   output side_type           out_side
);

   localparam logic [31:0] RMAX = 32'(5) << FRACTION_BITS;

   localparam logic [ANGLE_W-1:0] A_HARD_R_HI  = 10'd6;
   localparam logic [ANGLE_W-1:0] A_STRAIGHT   = 10'd157;
   localparam logic [ANGLE_W-1:0] A_LEFT_END   = 10'd308;
   localparam logic [ANGLE_W-1:0] A_HARD_L_HI  = 10'd320;
   localparam logic [ANGLE_W-1:0] A_BACK       = 10'd471;
   localparam logic [ANGLE_W-1:0] A_BACK_R_LO  = 10'd622;
   localparam logic [ANGLE_W-1:0] A_HALF       = 10'd314;
   localparam logic [ANGLE_W-1:0] A_FULL       = 10'd628;
   localparam logic [TURN_W-1:0]  TURN_MIN     = 8'd4;
   localparam logic [PROD_W-1:0]  WHEEL_K      = 22'd157;

   logic en1, en2, en3, en4;
   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff;

   logic [DSR_W-1:0]  dsr1_ff, dsr2_ff, dsr3_ff, dsr4_ff;
   side_type          side1_ff, side2_ff, side3_ff, side4_ff;
   logic [PROD_W-1:0] prod2_ff;
   logic [NUM_W-1:0]  num3_ff;
   logic [DVD_W-1:0]  dvd4_ff;

   logic [RADIUS_W-1:0] rad_clamp;
   logic [ANGLE_W-1:0]  ang;
   logic [ANGLE_W-1:0]  tri_full;
   logic [TURN_W-1:0]   turn;
   side_type            side1_in;
   logic [DSR_W-1:0]    dsr1_in;
   logic [PROD_W-1:0]   prod2_in;
   logic [NUM_W-1:0]    num3_in;
   logic [ADD_W-1:0]    sum4;
   logic [DVD_W-1:0]    dvd4_in;

   // advance a stage when it is empty or the next one advances
   assign en4 = !vld4_ff || out_ready;
   assign en3 = !vld3_ff || en4;
   assign en2 = !vld2_ff || en3;
   assign en1 = !vld1_ff || en2;
   assign req_ch.ready = en1;

   // stage 1: clamp radius, decode angle, form divisor 17 * t
   always_comb begin
      ang = req_ch.stick_angle;
      if (32'(req_ch.stick_radius) > RMAX) begin
         rad_clamp = RMAX[RADIUS_W-1:0];
      end else begin
         rad_clamp = req_ch.stick_radius;
      end
      side1_in.vel = VEL_W'({rad_clamp, 3'b000}) + VEL_W'({rad_clamp, 1'b0});
      side1_in.straight   = 1'b0;
      side1_in.outer_left = 1'b0;
      side1_in.back       = 1'b0;
      tri_full = 10'(TURN_MIN);
      if (ang <= A_HARD_R_HI || ang >= A_BACK_R_LO) begin
         side1_in.mcase = MC_HARD_RIGHT;
         side1_in.outer_left = 1'b1;
      end else if (ang < A_STRAIGHT) begin
         side1_in.mcase = MC_RIGHT;
         side1_in.outer_left = 1'b1;
         tri_full = ang;
      end else if (ang == A_STRAIGHT) begin
         side1_in.mcase = MC_STRAIGHT;
         side1_in.straight = 1'b1;
      end else if (ang < A_LEFT_END) begin
         side1_in.mcase = MC_LEFT;
         tri_full = A_HALF - ang;
      end else if (ang <= A_HARD_L_HI) begin
         side1_in.mcase = MC_HARD_LEFT;
      end else if (ang < A_BACK) begin
         side1_in.mcase = MC_BACK_LEFT;
         side1_in.back = 1'b1;
         tri_full = ang - A_HALF;
      end else if (ang == A_BACK) begin
         side1_in.mcase = MC_BACK;
         side1_in.straight = 1'b1;
         side1_in.back = 1'b1;
      end else begin
         side1_in.mcase = MC_BACK_RIGHT;
         side1_in.outer_left = 1'b1;
         side1_in.back = 1'b1;
         tri_full = A_FULL - ang;
      end
      turn = tri_full[TURN_W-1:0];
      dsr1_in = DSR_W'({turn, 4'b0000}) + DSR_W'(turn);
   end

   // stage 2: speed times 157
   assign prod2_in = PROD_W'(side1_ff.vel) * WHEEL_K;

   // stage 3: times track width
   assign num3_in = NUM_W'(prod2_ff) * NUM_W'(track_width);

   // stage 4: add half the full divisor, then drop the fraction bits
   always_comb begin
      sum4 = ADD_W'(num3_ff) + (ADD_W'(dsr3_ff) << (FRACTION_BITS - 1));
      dvd4_in = DVD_W'(sum4 >> FRACTION_BITS);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         if (en1) vld1_ff <= req_ch.valid;
         if (en2) vld2_ff <= vld1_ff;
         if (en3) vld3_ff <= vld2_ff;
         if (en4) vld4_ff <= vld3_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en1) begin
         side1_ff <= side1_in;
         dsr1_ff  <= dsr1_in;
      end
      if (en2) begin
         side2_ff <= side1_ff;
         dsr2_ff  <= dsr1_ff;
         prod2_ff <= prod2_in;
      end
      if (en3) begin
         side3_ff <= side2_ff;
         dsr3_ff  <= dsr2_ff;
         num3_ff  <= num3_in;
      end
      if (en4) begin
         side4_ff <= side3_ff;
         dsr4_ff  <= dsr3_ff;
         dvd4_ff  <= dvd4_in;
      end
   end

   assign out_valid = vld4_ff;
   assign out_dvd   = dvd4_ff;
   assign out_dsr   = dsr4_ff;
   assign out_side  = side4_ff;

endmodule

### sv/jtwv_div.sv
// ----------------------------------------------------------------------------
// Joystick to wheel velocities: pipelined divider
// Restoring long division, one quotient bit per register stage, with a
// sideband tag carried alongside each word.
// ----------------------------------------------------------------------------
module jtwv_div import jtwv_pkg::*; #(
   parameter int DVD_W = 25,
   parameter int TAG_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [DVD_W-1:0] in_dvd,
   input  logic [DSR_W-1:0] in_dsr,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [DVD_W-1:0] out_quo,
   output logic [TAG_W-1:0] out_tag
);

   logic [DVD_W:0]   en;
   logic             vld_ff  [DVD_W];
   logic [DSR_W-1:0] rem_ff  [DVD_W];
   logic [DVD_W-1:0] work_ff [DVD_W];
   logic [DSR_W-1:0] dsr_ff  [DVD_W];
   logic [TAG_W-1:0] tag_ff  [DVD_W];

   assign en[DVD_W] = out_ready;
   assign in_ready  = en[0];

   for (genvar k = 0; k < DVD_W; k++) begin : g_stage
      logic             prev_vld;
      logic [DSR_W-1:0] prev_rem;
      logic [DVD_W-1:0] prev_work;
      logic [DSR_W-1:0] prev_dsr;
      logic [TAG_W-1:0] prev_tag;
      logic [DSR_W:0]   trial;
      logic [DSR_W+1:0] diff;
      logic             ge;
      logic [DSR_W-1:0] rem_in;
      logic [DVD_W-1:0] work_in;

      // select the previous stage or the input port
      if (k == 0) begin : g_first
         assign prev_vld  = in_valid;
         assign prev_rem  = '0;
         assign prev_work = in_dvd;
         assign prev_dsr  = in_dsr;
         assign prev_tag  = in_tag;
      end else begin : g_next
         assign prev_vld  = vld_ff[k-1];
         assign prev_rem  = rem_ff[k-1];
         assign prev_work = work_ff[k-1];
         assign prev_dsr  = dsr_ff[k-1];
         assign prev_tag  = tag_ff[k-1];
      end

      assign en[k] = !vld_ff[k] || en[k+1];

      // shift in the next dividend bit, subtract if it fits
      always_comb begin
         trial   = {prev_rem, prev_work[DVD_W-1]};
         diff    = {1'b0, trial} - {2'b00, prev_dsr};
         ge      = !diff[DSR_W+1];
         rem_in  = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
         work_in = {prev_work[DVD_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en[k]) begin
            vld_ff[k] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in;
            work_ff[k] <= work_in;
            dsr_ff[k]  <= prev_dsr;
            tag_ff[k]  <= prev_tag;
         end
      end
   end

   assign out_valid = vld_ff[DVD_W-1];
   assign out_quo   = work_ff[DVD_W-1];
   assign out_tag   = tag_ff[DVD_W-1];

endmodule

### sv/jtwv_back.sv
// ----------------------------------------------------------------------------
// Joystick to wheel velocities: output stage
// Applies the wheel offset with the sign of the motion case, saturates to
// the speed range and holds the result word for the receiver.
// ----------------------------------------------------------------------------
module jtwv_back import jtwv_pkg::*; #(
   parameter int DVD_W = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [DVD_W-1:0] in_quo,
   input  side_type         in_side,
   jtwv_rsp_if.source       rsp_ch
);

   localparam int SW = DVD_W + 3;
   localparam logic signed [SW-1:0] HI = SW'(SPEED_MAX);
   localparam logic signed [SW-1:0] LO = SW'(SPEED_MIN);

   logic                      en;
   logic                      vld_ff;
   logic signed [SPEED_W-1:0] right_ff, right_in;
   logic signed [SPEED_W-1:0] left_ff, left_in;
   motion_type                case_ff;

   logic signed [SW-1:0] s_vel, s_off, plus, minus, right_raw, left_raw;

   function automatic logic signed [SPEED_W-1:0] sat(input logic signed [SW-1:0] x);
      logic signed [SPEED_W-1:0] y;
      if (x > HI) begin
         y = HI[SPEED_W-1:0];
      end else if (x < LO) begin
         y = LO[SPEED_W-1:0];
      end else begin
         y = x[SPEED_W-1:0];
      end
      return y;
   endfunction

   assign en       = !vld_ff || rsp_ch.ready;
   assign in_ready = en;

   // combine speed and offset per wheel, flip for the rear half-plane
   always_comb begin
      s_vel = $signed(SW'(in_side.vel));
      s_off = in_side.straight ? '0 : $signed(SW'(in_quo));
      plus  = s_vel + s_off;
      minus = s_vel - s_off;
      right_raw = in_side.outer_left ? minus : plus;
      left_raw  = in_side.outer_left ? plus : minus;
      if (in_side.back) begin
         right_raw = -right_raw;
         left_raw  = -left_raw;
      end
      right_in = sat(right_raw);
      left_in  = sat(left_raw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         right_ff <= right_in;
         left_ff  <= left_in;
         case_ff  <= in_side.mcase;
      end
   end

   assign rsp_ch.valid       = vld_ff;
   assign rsp_ch.right_speed = right_ff;
   assign rsp_ch.left_speed  = left_ff;
   assign rsp_ch.motion_case = case_ff;

endmodule
